### sv/spq_pkg.sv
// types, constants and sequencer states shared by the sorted priority queue
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int PRIO_BITS   = 8;
  localparam int ADDR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_PULL   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_TAIL,
    ST_HEAD,
    ST_RESP
  } state_e;

  typedef struct packed {
    op_e                  opcode;
    logic [ID_BITS-1:0]   task_id;
    logic [PRIO_BITS-1:0] task_priority;
  } cmd_t;

  typedef struct packed {
    logic                 head_valid;
    logic [ID_BITS-1:0]   head_task_id;
    logic [PRIO_BITS-1:0] head_priority;
    logic [CNT_BITS-1:0]  entry_count;
    logic                 duplicate_dropped;
    logic                 full_dropped;
  } rsp_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

endpackage

`default_nettype wire

### sv/spq_ram.sv
// generic single write port, single read port ram with registered read data
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### sv/sorted_priority_queue.sv
// Sorted priority queue of task ids, held in descending priority order in a
// circular ram. A command is taken when start is high and busy is low; its
// result appears on rsp_o for exactly one cycle with result_valid_o high and
// cannot be held off. Pull, clear and query go from the head read state
// straight to the result state. An insert walks the held entries one per
// cycle through the single ram port, comparing each with the new entry and
// shifting every entry behind the insertion point back by one slot, then
// fills the tail slot unless the queue is full; an insert into an empty
// queue goes straight to the tail write, and a duplicate or a full queue may
// end the walk early. Busy stays high until the result cycle is over.
`default_nettype none

module sorted_priority_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire spq_pkg::cmd_t cmd_i,
  output logic               busy,
  output logic               result_valid_o,
  output spq_pkg::rsp_t      rsp_o
);

  import spq_pkg::*;

  state_e               state_q, state_d;
  entry_t               new_q, new_d;
  entry_t               carry_q, carry_d;
  logic [ADDR_BITS-1:0] head_ptr_q, head_ptr_d;
  logic [ADDR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [ADDR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_BITS-1:0]  occ_q, occ_d;
  logic [CNT_BITS-1:0]  idx_q, idx_d;
  logic                 ins_q, ins_d;
  logic                 full_q, full_d;
  logic                 dup_q, dup_d;
  logic                 fdrop_q, fdrop_d;

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr;
  entry_t               ram_wdata;
  logic [ADDR_BITS-1:0] ram_raddr;
  entry_t               ram_rdata;
  logic                 last_entry;

  function automatic logic [ADDR_BITS-1:0] ptr_inc(input logic [ADDR_BITS-1:0] ptr);
    logic [ADDR_BITS-1:0] nxt;
    if (ptr == ADDR_BITS'(QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + ADDR_BITS'(1);
    end
    return nxt;
  endfunction

  spq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign last_entry = (idx_q == occ_q - CNT_BITS'(1));

  always_comb begin
    state_d    = state_q;
    new_d      = new_q;
    carry_d    = carry_q;
    head_ptr_d = head_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    occ_d      = occ_q;
    idx_d      = idx_q;
    ins_d      = ins_q;
    full_d     = full_q;
    dup_d      = dup_q;
    fdrop_d    = fdrop_q;
    ram_we     = 1'b0;
    ram_waddr  = wr_ptr_q;
    ram_wdata  = new_q;
    ram_raddr  = (state_q == ST_HEAD) ? head_ptr_q : rd_ptr_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          new_d.id   = cmd_i.task_id;
          new_d.prio = cmd_i.task_priority;
          dup_d      = 1'b0;
          fdrop_d    = 1'b0;
          ins_d      = 1'b0;
          full_d     = (occ_q == CNT_BITS'(QUEUE_DEPTH));
          rd_ptr_d   = head_ptr_q;
          wr_ptr_d   = head_ptr_q;
          idx_d      = '0;
          case (cmd_i.opcode)
            OP_INSERT: begin
              state_d = (occ_q == '0) ? ST_TAIL : ST_PREP;
            end
            OP_PULL: begin
              if (occ_q != '0) begin
                head_ptr_d = ptr_inc(head_ptr_q);
                occ_d      = occ_q - CNT_BITS'(1);
              end
              state_d = ST_HEAD;
            end
            OP_CLEAR: begin
              occ_d   = '0;
              state_d = ST_HEAD;
            end
            default: begin
              state_d = ST_HEAD;
            end
          endcase
        end
      end
      ST_PREP: begin
        // first read is in flight, data shows up in the first scan cycle
        rd_ptr_d = ptr_inc(rd_ptr_q);
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        rd_ptr_d = ptr_inc(rd_ptr_q);
        wr_ptr_d = ptr_inc(wr_ptr_q);
        idx_d    = idx_q + CNT_BITS'(1);
        if (ins_q) begin
          // shift the displaced entry one slot back
          ram_we    = 1'b1;
          ram_wdata = carry_q;
          carry_d   = ram_rdata;
          state_d   = last_entry ? ST_TAIL : ST_SCAN;
        end else if (ram_rdata.prio >= new_q.prio) begin
          if (ram_rdata == new_q) begin
            dup_d   = 1'b1;
            state_d = ST_HEAD;
          end else begin
            state_d = last_entry ? ST_TAIL : ST_SCAN;
          end
        end else if (full_q) begin
          // no equal priority entries past here, so no duplicate either
          fdrop_d = 1'b1;
          state_d = ST_HEAD;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = new_q;
          carry_d   = ram_rdata;
          ins_d     = 1'b1;
          state_d   = last_entry ? ST_TAIL : ST_SCAN;
        end
      end
      ST_TAIL: begin
        if (full_q) begin
          fdrop_d = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ins_q ? carry_q : new_q;
          occ_d     = occ_q + CNT_BITS'(1);
        end
        state_d = ST_HEAD;
      end
      ST_HEAD: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_ptr_q <= '0;
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      occ_q      <= '0;
      idx_q      <= '0;
      ins_q      <= 1'b0;
      full_q     <= 1'b0;
      dup_q      <= 1'b0;
      fdrop_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_ptr_q <= head_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      wr_ptr_q   <= wr_ptr_d;
      occ_q      <= occ_d;
      idx_q      <= idx_d;
      ins_q      <= ins_d;
      full_q     <= full_d;
      dup_q      <= dup_d;
      fdrop_q    <= fdrop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q   <= new_d;
    carry_q <= carry_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_RESP);

  always_comb begin
    rsp_o.head_valid        = (occ_q != '0);
    rsp_o.head_task_id      = (occ_q != '0) ? ram_rdata.id : '0;
    rsp_o.head_priority     = (occ_q != '0) ? ram_rdata.prio : '0;
    rsp_o.entry_count       = occ_q;
    rsp_o.duplicate_dropped = dup_q;
    rsp_o.full_dropped      = fdrop_q;
  end

endmodule

`default_nettype wire

### tb/sv/tb_sorted_priority_queue.sv
// self-checking testbench for the sorted priority queue: directed and random command words
module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int RANDOM_ITEMS = 1825;
  localparam int QUIET_TAIL   = 300;
  localparam int STALL_LIMIT  = 400;
  localparam int END_WAIT     = 25;

  class spq_scoreboard;
    entry_t      slots [QUEUE_DEPTH];
    int unsigned held;
    rsp_t        pending_rsp [$];
    int unsigned failures;
    int unsigned mismatches;
    int unsigned n_insert, n_pull, n_clear, n_query;
    int unsigned n_dup, n_full, n_checked, full_seen;

    function new();
      held = 0;
      failures = 0;
      mismatches = 0;
      n_insert = 0;
      n_pull = 0;
      n_clear = 0;
      n_query = 0;
      n_dup = 0;
      n_full = 0;
      n_checked = 0;
      full_seen = 0;
    endfunction

    // advance the predicted queue by one command and return its head report
    function rsp_t apply_command(cmd_t c);
      rsp_t r;
      int   i;
      int   pos;
      bit   hit;
      r = '0;
      case (c.opcode)
        OP_INSERT: begin
          n_insert++;
          hit = 1'b0;
          for (i = 0; i < held; i++) begin
            if (slots[i].id == c.task_id && slots[i].prio == c.task_priority) hit = 1'b1;
          end
          if (hit) begin
            r.duplicate_dropped = 1'b1;
            n_dup++;
          end else if (held >= QUEUE_DEPTH) begin
            r.full_dropped = 1'b1;
            n_full++;
          end else begin
            // new entry goes behind every entry of equal or higher priority
            pos = 0;
            while (pos < held && slots[pos].prio >= c.task_priority) pos++;
            for (i = held; i > pos; i--) slots[i] = slots[i-1];
            slots[pos].id = c.task_id;
            slots[pos].prio = c.task_priority;
            held++;
            if (held == QUEUE_DEPTH) full_seen++;
          end
        end
        OP_PULL: begin
          n_pull++;
          if (held > 0) begin
            for (i = 0; i + 1 < held; i++) slots[i] = slots[i+1];
            held--;
          end
        end
        OP_CLEAR: begin
          n_clear++;
          held = 0;
        end
        default: begin
          n_query++;
        end
      endcase
      if (held > 0) begin
        r.head_valid = 1'b1;
        r.head_task_id = slots[0].id;
        r.head_priority = slots[0].prio;
      end
      r.entry_count = CNT_BITS'(held);
      return r;
    endfunction

    function void note_command(cmd_t c);
      pending_rsp.push_back(apply_command(c));
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp_r;
      bit   bad;
      if (pending_rsp.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: valid=%0b id=%h prio=%h cnt=%0d dup=%0b full=%0b",
                   got.head_valid, got.head_task_id, got.head_priority, got.entry_count,
                   got.duplicate_dropped, got.full_dropped);
        return;
      end
      exp_r = pending_rsp.pop_front();
      n_checked++;
      bad = 1'b0;
      if (got.head_valid !== exp_r.head_valid) bad = 1'b1;
      if (got.head_task_id !== exp_r.head_task_id) bad = 1'b1;
      if (got.head_priority !== exp_r.head_priority) bad = 1'b1;
      if (got.entry_count !== exp_r.entry_count) bad = 1'b1;
      if (got.duplicate_dropped !== exp_r.duplicate_dropped) bad = 1'b1;
      if (got.full_dropped !== exp_r.full_dropped) bad = 1'b1;
      if (bad) begin
        failures++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch at %0t", n_checked, $realtime);
          $display("  expected valid=%0b id=%h prio=%h cnt=%0d dup=%0b full=%0b",
                   exp_r.head_valid, exp_r.head_task_id, exp_r.head_priority,
                   exp_r.entry_count, exp_r.duplicate_dropped, exp_r.full_dropped);
          $display("  actual   valid=%0b id=%h prio=%h cnt=%0d dup=%0b full=%0b",
                   got.head_valid, got.head_task_id, got.head_priority, got.entry_count,
                   got.duplicate_dropped, got.full_dropped);
        end
      end
    endfunction
  endclass

  logic  clk_i   = 1'b0;
  logic  rst_ni  = 1'b0;
  logic  start_i = 1'b0;
  cmd_t  cmd_r   = '0;
  logic  busy;
  logic  result_valid_o;
  rsp_t  rsp_w;
  int    stall_cycles = 0;

  spq_scoreboard sb = new();

  sorted_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start_i),
    .cmd_i          (cmd_r),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_w)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // accepted words, results and the stall watchdog, all sampled at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy) sb.note_command(cmd_r);
      if (result_valid_o) sb.check_result(rsp_w);
      if ((start_i && !busy) || result_valid_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic cmd_t make_cmd(logic [1:0] op, logic [15:0] id, logic [7:0] prio);
    cmd_t c;
    c.opcode = op_e'(op);
    c.task_id = id;
    c.task_priority = prio;
    return c;
  endfunction

  function automatic cmd_t random_cmd(int unsigned ins_pct, int unsigned pull_pct);
    cmd_t        c;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) c.opcode = OP_INSERT;
    else if (r < ins_pct + pull_pct) c.opcode = OP_PULL;
    else if (r < 99) c.opcode = OP_QUERY;
    else c.opcode = OP_CLEAR;
    // a small id pool and narrow priorities make duplicates and ties common
    case ($urandom_range(0, 3))
      0, 1: c.task_id = 16'($urandom_range(0, 7));
      2: c.task_id = 16'($urandom);
      default: c.task_id = 16'hfff8 | 16'($urandom_range(0, 7));
    endcase
    case ($urandom_range(0, 3))
      0: c.task_priority = 8'($urandom_range(0, 3));
      1: c.task_priority = $urandom_range(0, 1) ? 8'hff : 8'h00;
      default: c.task_priority = 8'($urandom);
    endcase
    return c;
  endfunction

  // hold the word until taken, then maybe drop start for a burst
  task automatic issue(cmd_t c, int unsigned idle_pct);
    start_i <= 1'b1;
    cmd_r <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic drain_all();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int          k;
    int          done;
    int          len;
    int unsigned mode;
    int unsigned ins_pct;
    int unsigned pull_pct;
    int unsigned idle_pct;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue corners
    issue(make_cmd(OP_QUERY, 16'hffff, 8'hff), 30);
    issue(make_cmd(OP_PULL, 16'h0, 8'h0), 30);
    issue(make_cmd(OP_CLEAR, 16'h0, 8'h0), 30);
    issue(make_cmd(OP_INSERT, 16'h0000, 8'h00), 30);
    issue(make_cmd(OP_INSERT, 16'hffff, 8'hff), 30);
    issue(make_cmd(OP_INSERT, 16'hffff, 8'hff), 30);
    // equal priority leaves in arrival order
    issue(make_cmd(OP_INSERT, 16'h1234, 8'hff), 30);
    issue(make_cmd(OP_PULL, 16'h0, 8'h0), 30);
    // fill up with tied priorities
    for (k = 0; k < 14; k++)
      issue(make_cmd(OP_INSERT, 16'h0100 + 16'(k), 8'((k % 4) * 85)), 30);
    issue(make_cmd(OP_INSERT, 16'hbeef, 8'h40), 30);
    issue(make_cmd(OP_INSERT, 16'h0000, 8'h00), 30);
    issue(make_cmd(OP_CLEAR, 16'hffff, 8'hff), 30);
    issue(make_cmd(OP_QUERY, 16'h0, 8'h0), 30);
    drain_all();

    done = 0;
    while (done < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      case (mode)
        0: begin ins_pct = 85; pull_pct = 10; end
        1: begin ins_pct = 20; pull_pct = 72; end
        default: begin ins_pct = 50; pull_pct = 40; end
      endcase
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 30;
        default: idle_pct = 70;
      endcase
      len = $urandom_range(20, 60);
      for (k = 0; k < len && done < RANDOM_ITEMS; k++) begin
        if (done >= RANDOM_ITEMS - QUIET_TAIL) idle_pct = 0;
        issue(random_cmd(ins_pct, pull_pct), idle_pct);
        done++;
        if (done == RANDOM_ITEMS / 2) drain_all();
      end
    end
    drain_all();
    repeat (END_WAIT) @(posedge clk_i);

    $display("ran %0d words: %0d inserts, %0d pulls, %0d clears, %0d queries; %0d results checked",
             sb.n_insert + sb.n_pull + sb.n_clear + sb.n_query, sb.n_insert, sb.n_pull,
             sb.n_clear, sb.n_query, sb.n_checked);
    $display("duplicates dropped %0d, full drops %0d, queue filled %0d times, %0d failures",
             sb.n_dup, sb.n_full, sb.full_seen, sb.failures);
    if (sb.failures == 0 && sb.pending_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
